FILE: sv/shabsh_pkg.sv
// Shared types and constants of the SHA-256 byte stream hasher.
package shabsh_pkg;

	// Input operation codes.
	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Padding and length constants.
	localparam logic [7:0]  PAD_MARKER   = 8'h80;
	localparam logic [5:0]  LEN_POS      = 6'd56;
	localparam logic [5:0]  LAST_POS     = 6'd63;
	localparam logic [63:0] BLOCK_BITS   = 64'd512;

	// Eight 32-bit hash words, word 0 first.
	typedef logic [0:7][31:0] hash_t;

	// Round constants, round 0 first.
	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Initial hash value.
	localparam hash_t INIT_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Commands from the sequencer to the compression core.
	typedef struct packed {
		logic       shift_en;
		logic [7:0] shift_byte;
		logic       start;
		logic       init;
	} core_cmd_t;

	// Status from the compression core.
	typedef struct packed {
		logic busy;
	} core_stat_t;

endpackage

FILE: sv/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte stream hasher: sequencer for absorb, padding and digest transfer.
//
// Usage: the input channel (in_valid/in_ready) carries one item per transfer.
// An absorb item (operation 0) appends data_byte to the current 64-byte block;
// a finish item (operation 1) pads the message, hashes it and produces four
// result transfers on the output channel (out_valid/out_ready): digest_word
// holds two hash words big-endian, word_index counts 0..3 and last_word marks
// the fourth. After the fourth transfer a new message starts from the initial
// hash value.
// Timing: an absorb is taken whenever the sequencer is idle; the byte that fills
// a block starts a compression, and the block is busy through 64 rounds of the
// single round unit, the chaining add and the return to idle. A finish shifts
// padding bytes one per cycle, pausing while a compression runs, and runs one or
// two compressions before the first digest word is offered. The digest words are
// held until the receiver takes them; no input is taken while they wait or while a
// compression runs.
// Reset clears the byte count, the bit count and restores the initial hash.
module sha256_byte_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ABS_WAIT,
		S_PAD,
		S_PAD_WAIT,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [5:0]             fill_q;
	logic [63:0]            bits_q;
	logic [63:0]            len_q;
	logic                   first_q;
	logic                   lph_q;
	logic                   fin_q;
	logic [1:0]             idx_q;

	shabsh_pkg::core_cmd_t  cmd;
	shabsh_pkg::core_stat_t stat;
	shabsh_pkg::hash_t      hash;

	logic                   in_xfer;
	logic                   out_xfer;
	logic                   len_sel;
	logic [7:0]             pad_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	// Padding byte: marker first, then zeros, then the bit length from byte 56 on.
	assign len_sel  = !first_q && ((fill_q == shabsh_pkg::LEN_POS) || lph_q);
	assign pad_byte = first_q ? shabsh_pkg::PAD_MARKER : (len_sel ? len_q[63:56] : 8'h00);

	// Commands to the compression core.
	always_comb begin
		cmd.shift_en   = (in_xfer && (operation == shabsh_pkg::OP_ABSORB))
			|| (state_q == S_PAD);
		cmd.shift_byte = (state_q == S_PAD) ? pad_byte : data_byte;
		cmd.start      = cmd.shift_en && (fill_q == shabsh_pkg::LAST_POS);
		cmd.init       = out_xfer && (idx_q == 2'd3);
	end

	shabsh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.hash   (hash)
	);

	// Message sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			len_q   <= '0;
			first_q <= 1'b0;
			lph_q   <= 1'b0;
			fin_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (operation == shabsh_pkg::OP_FINISH) begin
							len_q   <= bits_q + {55'd0, fill_q, 3'd0};
							first_q <= 1'b1;
							lph_q   <= 1'b0;
							state_q <= S_PAD;
						end else begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == shabsh_pkg::LAST_POS) begin
								bits_q  <= bits_q + shabsh_pkg::BLOCK_BITS;
								state_q <= S_ABS_WAIT;
							end
						end
					end
				end
				S_ABS_WAIT: begin
					if (!stat.busy) begin
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					fill_q  <= fill_q + 6'd1;
					if (len_sel) begin
						lph_q <= 1'b1;
						len_q <= {len_q[55:0], 8'h00};
					end
					if (fill_q == shabsh_pkg::LAST_POS) begin
						fin_q   <= len_sel;
						state_q <= S_PAD_WAIT;
					end
				end
				S_PAD_WAIT: begin
					idx_q <= '0;
					if (!stat.busy) begin
						state_q <= fin_q ? S_EMIT : S_PAD;
					end
				end
				S_EMIT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							fill_q  <= '0;
							bits_q  <= '0;
							lph_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Digest word selection from the held chaining value.
	assign digest_word = {hash[{idx_q, 1'b0}], hash[{idx_q, 1'b1}]};
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 2'd3);

endmodule

FILE: sv/shabsh_core.sv
// Block buffer, message schedule window and one-round-per-cycle compression unit.
module shabsh_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shabsh_pkg::core_cmd_t  cmd,
	output shabsh_pkg::core_stat_t stat,
	output shabsh_pkg::hash_t      hash
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROUND,
		C_ADD
	} core_state_t;

	core_state_t       state_q;
	logic [5:0]        cnt_q;
	shabsh_pkg::hash_t hash_q;
	shabsh_pkg::hash_t v_q;
	logic [511:0]      blk_q;

	logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
	logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// Schedule window taps: oldest word in the top 32 bits.
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];

	// Next schedule word.
	always_comb begin
		s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		w_new = w0 + s0 + w9 + s1;
	end

	// One compression round on the working variables.
	always_comb begin
		big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + big_s1 + ch + shabsh_pkg::ROUND_K[cnt_q] + w0;
		t2     = big_s0 + maj;
	end

	// Sequencer, round counter and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			hash_q  <= shabsh_pkg::INIT_HASH;
		end else begin
			case (state_q)
				C_IDLE: begin
					cnt_q <= '0;
					if (cmd.init) begin
						hash_q <= shabsh_pkg::INIT_HASH;
					end
					if (cmd.start) begin
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == shabsh_pkg::LAST_POS) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Working variables and the block buffer, filled a byte at a time, that becomes the schedule window.
	always_ff @(posedge clk) begin
		if (state_q == C_ROUND) begin
			v_q   <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
			blk_q <= {blk_q[479:0], w_new};
		end else begin
			if (cmd.start) begin
				v_q <= hash_q;
			end
			if (cmd.shift_en) begin
				blk_q <= {blk_q[503:0], cmd.shift_byte};
			end
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign hash      = hash_q;

endmodule
